>>> sv/mtep_pkg.sv
`timescale 1ns / 1ps
// shared constants and types of the midi track event parser
package mtep_pkg;

    localparam int TEMPO_ENTRIES_DEF = 64;
    localparam int MS_PER_S          = 1000;
    localparam int CFG_IDX_W         = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_TPQ  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SEEK = CFG_IDX_W'(1);

    localparam logic [14:0] TPQ_RESET     = 15'd480;
    localparam logic [23:0] DEFAULT_TEMPO = 24'd500000;
    localparam logic [30:0] MAX31         = 31'h7FFF_FFFF;

    localparam logic [7:0] STATUS_META  = 8'hFF;
    localparam logic [7:0] STATUS_SYSEX = 8'hF0;
    localparam logic [7:0] META_TEMPO   = 8'h51;
    localparam logic [7:0] NOTE_LO      = 8'h80;
    localparam logic [7:0] NOTE_HI      = 8'h9F;

    localparam logic [2:0] KIND_INVALID = 3'd0;
    localparam logic [2:0] KIND_CHAN2   = 3'd1;
    localparam logic [2:0] KIND_CHAN3   = 3'd2;
    localparam logic [2:0] KIND_SYSEX   = 3'd3;
    localparam logic [2:0] KIND_META    = 3'd4;

    // request from the parser to the time unit
    typedef struct packed {
        logic        start;
        logic [30:0] ticks;
        logic        append;
        logic [23:0] capture;
    } tu_req_t;

    // answer of the time unit
    typedef struct packed {
        logic        busy;
        logic        done;
        logic [30:0] ms;
    } tu_rsp_t;

endpackage

>>> sv/mtep_if.sv
`timescale 1ns / 1ps
// channel interfaces: track bytes, parsed results, configuration writes
interface mtep_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       track_start;
    logic       tempo_track;
    modport source (output valid, data_byte, track_start, tempo_track, input ready);
    modport sink   (input valid, data_byte, track_start, tempo_track, output ready);
endinterface

interface mtep_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [7:0]  status;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [27:0] payload_length;
    logic [7:0]  payload_byte;
    logic        is_payload;
    logic        last;
    logic [30:0] event_ticks;
    logic [30:0] time_ms;
    modport source (output valid, event_kind, status, first_data, second_data,
                    payload_length, payload_byte, is_payload, last, event_ticks,
                    time_ms, input ready);
    modport sink   (input valid, event_kind, status, first_data, second_data,
                    payload_length, payload_byte, is_payload, last, event_ticks,
                    time_ms, output ready);
endinterface

interface mtep_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [30:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/midi_track_event_parser_unit.sv
`timescale 1ns / 1ps
// midi track event parser top level: byte parser, result register, time unit
//
//  channel  | dir | transfer carries
//  in_ch    | in  | data_byte, track_start, tempo_track
//  out_ch   | out | event header or payload byte with ticks and time
//  cfg      | in  | index 0 ticks_per_quarter, index 1 seek_ms
//
// a byte that completes no result leaves the parser ready for the next byte
// a byte that gives a result holds the parser while the time unit walks the tempo map,
//   multiplies and runs the 55-step restoring divider, and the result is handed off
// reset puts the map at one default entry (120 bpm), no clearing pass
// a result waits in the output register; the next byte is taken meanwhile,
//   and a stalled sink holds the parser only when the next result is ready
module midi_track_event_parser_unit #(
    parameter int TEMPO_ENTRIES = mtep_pkg::TEMPO_ENTRIES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    mtep_in_if.sink    in_ch,
    mtep_out_if.source out_ch,
    mtep_cfg_if.sink   cfg
);
    import mtep_pkg::*;

    typedef enum logic [2:0] {
        PH_DELTA, PH_STATUS, PH_FIRST, PH_SECOND, PH_LEN, PH_PAYLOAD
    } phase_t;

    typedef enum logic [1:0] {C_IDLE, C_TIME, C_PUT} ctl_t;

    // configuration
    logic [14:0] tpq_reg;
    logic [30:0] seek_reg;

    // parser state
    phase_t      phase_reg;
    logic [7:0]  run_reg, cur_reg, held_reg;
    logic [27:0] acc_reg, prem_reg, decl_reg;
    logic [30:0] tick_reg;
    logic [23:0] cap_reg;

    // control and pending result
    ctl_t        ctl_reg;
    tu_req_t     req_reg;
    tu_rsp_t     rsp;
    logic [2:0]  p_kind_reg;
    logic [7:0]  p_st_reg, p_d1_reg, p_d2_reg, p_pb_reg;
    logic [27:0] p_len_reg;
    logic        p_isp_reg, p_last_reg;
    logic [30:0] p_ticks_reg, p_ms_reg;

    // output register
    logic        o_valid_reg;
    logic [2:0]  o_kind_reg;
    logic [7:0]  o_st_reg, o_d1_reg, o_d2_reg, o_pb_reg;
    logic [27:0] o_len_reg;
    logic        o_isp_reg, o_last_reg;
    logic [30:0] o_ticks_reg, o_ms_reg;

    // next parser state
    phase_t      phase_next;
    logic [7:0]  run_next, cur_next, held_next;
    logic [27:0] acc_next, prem_next, decl_next;
    logic [30:0] tick_next;
    logic [23:0] cap_next;

    logic        em, fin;
    logic [2:0]  e_kind;
    logic [7:0]  e_st, e_d1, e_d2, e_pb;
    logic [27:0] e_len;
    logic        e_isp, e_last;
    logic [7:0]  b;
    logic [31:0] tsum;
    logic [27:0] pidx;
    logic        accept, load_out, before_seek;

    assign b      = in_ch.data_byte;
    assign accept = in_ch.valid && in_ch.ready;

    always_comb
    begin
        // track start clears the partial event before the byte is parsed
        phase_next = in_ch.track_start ? PH_DELTA : phase_reg;
        tick_next  = in_ch.track_start ? 31'd0 : tick_reg;
        run_next   = in_ch.track_start ? 8'd0 : run_reg;
        cur_next   = in_ch.track_start ? 8'd0 : cur_reg;
        held_next  = in_ch.track_start ? 8'd0 : held_reg;
        acc_next   = in_ch.track_start ? 28'd0 : acc_reg;
        prem_next  = in_ch.track_start ? 28'd0 : prem_reg;
        decl_next  = decl_reg;
        cap_next   = cap_reg;
        em     = 1'b0;
        fin    = 1'b0;
        e_kind = KIND_INVALID;
        e_st   = 8'd0;
        e_d1   = 8'd0;
        e_d2   = 8'd0;
        e_pb   = 8'd0;
        e_len  = 28'd0;
        e_isp  = 1'b0;
        e_last = 1'b1;
        tsum   = 32'd0;
        pidx   = 28'd0;

        unique case (phase_next)
            PH_DELTA:
            begin
                acc_next = {acc_next[20:0], b[6:0]};
                if (!b[7])
                begin
                    tsum       = {1'b0, tick_next} + {4'd0, acc_next};
                    tick_next  = tsum[31] ? MAX31 : tsum[30:0];
                    acc_next   = 28'd0;
                    phase_next = PH_STATUS;
                end
            end
            PH_STATUS, PH_FIRST:
            begin
                if (phase_next == PH_STATUS && b >= STATUS_SYSEX && b != STATUS_META)
                begin
                    // F0 to FE (sysex, escape and other system statuses) clear running status
                    cur_next   = b;
                    held_next  = 8'd0;
                    run_next   = 8'd0;
                    acc_next   = 28'd0;
                    phase_next = PH_LEN;
                end
                else if (phase_next == PH_STATUS && b[7])
                begin
                    cur_next   = b;
                    run_next   = (b == STATUS_META) ? 8'd0 : b;
                    phase_next = PH_FIRST;
                end
                else
                begin
                    // data byte: running status in status position, or first data
                    if (phase_next == PH_STATUS)
                    begin
                        cur_next = run_next;
                    end
                    held_next = b;
                    unique case (cur_next[7:4])
                        4'h8, 4'h9, 4'hA, 4'hB, 4'hE:
                        begin
                            phase_next = PH_SECOND;
                        end
                        4'hC, 4'hD:
                        begin
                            phase_next = PH_DELTA;
                            acc_next   = 28'd0;
                            em         = 1'b1;
                            e_kind     = KIND_CHAN2;
                            e_st       = cur_next;
                            e_d1       = held_next;
                        end
                        4'hF:
                        begin
                            phase_next = PH_LEN;
                            acc_next   = 28'd0;
                        end
                        default:
                        begin
                            phase_next = PH_DELTA;
                            acc_next   = 28'd0;
                            em         = 1'b1;
                            e_kind     = KIND_INVALID;
                            e_st       = cur_next;
                            e_d1       = held_next;
                        end
                    endcase
                end
            end
            PH_SECOND:
            begin
                phase_next = PH_DELTA;
                acc_next   = 28'd0;
                em         = 1'b1;
                e_kind     = KIND_CHAN3;
                e_st       = cur_next;
                e_d1       = held_next;
                e_d2       = b;
            end
            PH_LEN:
            begin
                acc_next = {acc_next[20:0], b[6:0]};
                if (!b[7])
                begin
                    decl_next = acc_next;
                    prem_next = acc_next;
                    cap_next  = 24'd0;
                    em        = 1'b1;
                    e_kind    = (cur_next == STATUS_META) ? KIND_META : KIND_SYSEX;
                    e_st      = cur_next;
                    e_d1      = held_next;
                    e_len     = acc_next;
                    e_last    = (acc_next == 28'd0);
                    if (acc_next == 28'd0)
                    begin
                        fin        = 1'b1;
                        phase_next = PH_DELTA;
                        acc_next   = 28'd0;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                pidx = decl_next - prem_next;
                if (pidx < 28'd3)
                begin
                    cap_next = {cap_next[15:0], b};
                end
                if (prem_next != 28'd0)
                begin
                    prem_next = prem_next - 28'd1;
                end
                em     = 1'b1;
                e_kind = (cur_next == STATUS_META) ? KIND_META : KIND_SYSEX;
                e_st   = cur_next;
                e_d1   = held_next;
                e_len  = decl_next;
                e_pb   = b;
                e_isp  = 1'b1;
                e_last = (prem_next == 28'd0);
                if (prem_next == 28'd0)
                begin
                    fin        = 1'b1;
                    phase_next = PH_DELTA;
                    acc_next   = 28'd0;
                end
            end
            default:
            begin
                phase_next = PH_DELTA;
                acc_next   = 28'd0;
            end
        endcase
    end

    // the result register is free when empty or being taken this cycle
    assign load_out    = (ctl_reg == C_PUT) && (!o_valid_reg || out_ch.ready);
    assign before_seek = (p_ms_reg < seek_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpq_reg     <= TPQ_RESET;
            seek_reg    <= 31'd0;
            phase_reg   <= PH_DELTA;
            run_reg     <= 8'd0;
            cur_reg     <= 8'd0;
            held_reg    <= 8'd0;
            acc_reg     <= 28'd0;
            prem_reg    <= 28'd0;
            decl_reg    <= 28'd0;
            tick_reg    <= 31'd0;
            cap_reg     <= 24'd0;
            ctl_reg     <= C_IDLE;
            req_reg     <= '0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            // one-cycle start pulse for each byte that gives a result
            req_reg.start <= (ctl_reg == C_IDLE) && accept && em;
            if (cfg.valid)
            begin
                priority if (cfg.index == CFG_TPQ)
                begin
                    tpq_reg <= cfg.data[14:0];
                end
                else if (cfg.index == CFG_SEEK)
                begin
                    seek_reg <= cfg.data;
                end
            end

            if (out_ch.ready && !load_out)
            begin
                o_valid_reg <= 1'b0;
            end

            unique case (ctl_reg)
                C_IDLE:
                begin
                    if (accept)
                    begin
                        phase_reg <= phase_next;
                        run_reg   <= run_next;
                        cur_reg   <= cur_next;
                        held_reg  <= held_next;
                        acc_reg   <= acc_next;
                        prem_reg  <= prem_next;
                        decl_reg  <= decl_next;
                        tick_reg  <= tick_next;
                        cap_reg   <= cap_next;
                        if (em)
                        begin
                            // set-tempo of the tempo track is appended by the time unit
                            req_reg.ticks   <= tick_next;
                            req_reg.capture <= cap_next;
                            req_reg.append  <= fin && in_ch.tempo_track
                                && cur_next == STATUS_META && held_next == META_TEMPO
                                && decl_next >= 28'd3;
                            ctl_reg <= C_TIME;
                        end
                    end
                end
                C_TIME:
                begin
                    if (rsp.done)
                    begin
                        p_ms_reg <= rsp.ms;
                        ctl_reg  <= C_PUT;
                    end
                end
                C_PUT:
                begin
                    if (load_out)
                    begin
                        o_valid_reg <= 1'b1;
                        ctl_reg     <= C_IDLE;
                    end
                end
                default:
                begin
                    ctl_reg <= C_IDLE;
                end
            endcase
        end
    end

    // pending and output payload
    always_ff @(posedge clk)
    begin
        if (ctl_reg == C_IDLE && accept && em)
        begin
            p_kind_reg  <= e_kind;
            p_st_reg    <= e_st;
            p_d1_reg    <= e_d1;
            p_d2_reg    <= e_d2;
            p_len_reg   <= e_len;
            p_pb_reg    <= e_pb;
            p_isp_reg   <= e_isp;
            p_last_reg  <= e_last;
            p_ticks_reg <= tick_next;
        end
        if (load_out)
        begin
            o_kind_reg  <= p_kind_reg;
            // note statuses are hidden before the seek point
            o_st_reg    <= (before_seek && p_st_reg >= NOTE_LO && p_st_reg <= NOTE_HI)
                           ? 8'd0 : p_st_reg;
            o_d1_reg    <= p_d1_reg;
            o_d2_reg    <= p_d2_reg;
            o_len_reg   <= p_len_reg;
            o_pb_reg    <= p_pb_reg;
            o_isp_reg   <= p_isp_reg;
            o_last_reg  <= p_last_reg;
            o_ticks_reg <= p_ticks_reg;
            o_ms_reg    <= before_seek ? 31'd0 : p_ms_reg;
        end
    end

    mtep_time_unit #(
        .TEMPO_ENTRIES (TEMPO_ENTRIES)
    ) u_time (
        .clk   (clk),
        .rst_n (rst_n),
        .tpq   (tpq_reg),
        .req   (req_reg),
        .rsp   (rsp)
    );

    assign in_ch.ready           = (ctl_reg == C_IDLE);
    assign cfg.ready             = 1'b1;
    assign out_ch.valid          = o_valid_reg;
    assign out_ch.event_kind     = o_kind_reg;
    assign out_ch.status         = o_st_reg;
    assign out_ch.first_data     = o_d1_reg;
    assign out_ch.second_data    = o_d2_reg;
    assign out_ch.payload_length = o_len_reg;
    assign out_ch.payload_byte   = o_pb_reg;
    assign out_ch.is_payload     = o_isp_reg;
    assign out_ch.last           = o_last_reg;
    assign out_ch.event_ticks    = o_ticks_reg;
    assign out_ch.time_ms        = o_ms_reg;

    a_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !rsp.busy && !req_reg.start)
        else $error("byte taken while time unit at work");

    a_done_time: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> ctl_reg == C_TIME)
        else $error("time result outside wait state");

    a_start_after: assert property (@(posedge clk) disable iff (!rst_n)
        accept && em |=> ctl_reg == C_TIME && req_reg.start)
        else $error("result byte did not start time unit");

    a_payload_kind: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && o_isp_reg |-> o_kind_reg == KIND_SYSEX || o_kind_reg == KIND_META)
        else $error("payload result with channel kind");

endmodule

>>> sv/mtep_time_unit.sv
`timescale 1ns / 1ps
// tempo map store with sequential map walk, multiply and restoring divider
module mtep_time_unit #(
    parameter int TEMPO_ENTRIES = mtep_pkg::TEMPO_ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [14:0]       tpq,
    input  mtep_pkg::tu_req_t req,
    output mtep_pkg::tu_rsp_t rsp
);
    import mtep_pkg::*;

    localparam int CW = $clog2(TEMPO_ENTRIES + 1);
    localparam int AW = (TEMPO_ENTRIES > 1) ? $clog2(TEMPO_ENTRIES) : 1;
    localparam int NW = 55;
    localparam int SW = $clog2(NW);

    typedef struct packed {
        logic [23:0] value;
        logic [30:0] ticks;
        logic [30:0] ms;
    } entry_t;

    localparam entry_t ENTRY0 = '{value: DEFAULT_TEMPO, ticks: 31'd0, ms: 31'd0};

    typedef enum logic [2:0] {T_IDLE, T_READ, T_CMP, T_MUL, T_DIV, T_SUM} tstate_t;

    entry_t mem [TEMPO_ENTRIES];

    tstate_t     state_reg;
    logic [CW-1:0] cnt_reg, idx_reg;
    logic [30:0] t_reg;
    logic        app_reg;
    logic [23:0] cap_reg;
    logic [24:0] div_reg;
    entry_t      rd_reg, sel_reg;
    logic [NW-1:0] num_reg;
    logic [24:0] rem_reg;
    logic [SW-1:0] step_reg;
    logic        done_reg;
    logic [30:0] ms_reg;

    logic [14:0] tpq_eff;
    logic [CW-1:0] idx_inc;
    logic [30:0] diff;
    logic [25:0] rem_sh;
    logic        qbit;
    logic [55:0] sum;
    logic [30:0] ms_sat;
    logic        do_app;

    always_comb
    begin
        tpq_eff = (tpq == 15'd0) ? 15'd1 : tpq;
        idx_inc = idx_reg + CW'(1);
        diff    = (t_reg >= sel_reg.ticks) ? (t_reg - sel_reg.ticks) : 31'd0;
        rem_sh  = {rem_reg, num_reg[NW-1]};
        qbit    = (rem_sh >= {1'b0, div_reg});
        sum     = 56'(num_reg) + 56'(sel_reg.ms);
        ms_sat  = (sum > 56'(MAX31)) ? MAX31 : sum[30:0];
        do_app  = (state_reg == T_SUM) && app_reg && (cnt_reg < CW'(TEMPO_ENTRIES));
    end

    // map store, entry 0 is the fixed default tempo and never written
    always_ff @(posedge clk)
    begin
        if (do_app)
        begin
            mem[cnt_reg[AW-1:0]] <= '{value: cap_reg, ticks: t_reg, ms: ms_sat};
        end
        if (state_reg == T_READ)
        begin
            rd_reg <= (idx_reg == CW'(0)) ? ENTRY0 : mem[idx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            cnt_reg   <= CW'(1);
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == T_SUM);
            unique case (state_reg)
                T_IDLE:
                begin
                    if (req.start)
                    begin
                        t_reg     <= req.ticks;
                        app_reg   <= req.append;
                        cap_reg   <= req.capture;
                        idx_reg   <= '0;
                        div_reg   <= 25'(tpq_eff) * 25'(MS_PER_S);
                        state_reg <= T_READ;
                    end
                end
                T_READ:
                begin
                    state_reg <= T_CMP;
                end
                T_CMP:
                begin
                    // walk stops at the first entry later than the event or at the last filled entry
                    if (t_reg >= rd_reg.ticks)
                    begin
                        sel_reg <= rd_reg;
                        if (idx_inc < cnt_reg)
                        begin
                            idx_reg   <= idx_inc;
                            state_reg <= T_READ;
                        end
                        else
                        begin
                            state_reg <= T_MUL;
                        end
                    end
                    else
                    begin
                        state_reg <= T_MUL;
                    end
                end
                T_MUL:
                begin
                    num_reg   <= NW'(diff) * NW'(sel_reg.value);
                    rem_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= T_DIV;
                end
                T_DIV:
                begin
                    rem_reg  <= qbit ? 25'(rem_sh - {1'b0, div_reg}) : rem_sh[24:0];
                    num_reg  <= {num_reg[NW-2:0], qbit};
                    step_reg <= step_reg + SW'(1);
                    if (step_reg == SW'(NW - 1))
                    begin
                        state_reg <= T_SUM;
                    end
                end
                T_SUM:
                begin
                    ms_reg    <= ms_sat;
                    if (do_app)
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                    state_reg <= T_IDLE;
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign rsp.busy = (state_reg != T_IDLE);
    assign rsp.done = done_reg;
    assign rsp.ms   = ms_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != CW'(0) && cnt_reg <= CW'(TEMPO_ENTRIES))
        else $error("tempo map count out of range");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == T_CMP |-> idx_reg < cnt_reg)
        else $error("map walk beyond filled entries");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == T_IDLE && !$past(done_reg))
        else $error("time unit done not a single pulse");

endmodule
